// ===== hw/rtl/utoa_pkg.sv =====
// ----------------------------------------------------------------------------
// utoa_pkg
// Shared types, constants and helper functions of the unsigned to ASCII
// digit converter.
// ----------------------------------------------------------------------------
package utoa_pkg;

    localparam int IN_BITS          = 64;
    localparam int OPC_BITS         = 2;
    localparam int CHAR_BITS        = 7;
    localparam int NIB_BITS         = 4;
    localparam int VALUE_BITS_DEF   = 64;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER = 7'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 7'h41;
    localparam logic [NIB_BITS-1:0]  NIB_TEN    = 4'd10;
    localparam logic [NIB_BITS-1:0]  NIB_FIVE   = 4'd5;
    localparam logic [NIB_BITS-1:0]  NIB_THREE  = 4'd3;

    typedef enum logic [1:0] {
        MODE_DEC,
        MODE_LOWER,
        MODE_UPPER
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // Decimal digits needed for the largest value of the given bit width.
    function automatic int dec_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

    function automatic int hex_digits(input int bits);
        return (bits + NIB_BITS - 1) / NIB_BITS;
    endfunction

    // ASCII code of one digit; digits above nine use the chosen letter case.
    function automatic logic [CHAR_BITS-1:0] nib_to_char(
        input logic [NIB_BITS-1:0] nib,
        input logic                upper
    );
        logic [CHAR_BITS-1:0] res;
        if (nib < NIB_TEN) begin
            res = CHAR_ZERO + CHAR_BITS'(nib);
        end else if (upper) begin
            res = CHAR_UPPER + CHAR_BITS'(nib - NIB_TEN);
        end else begin
            res = CHAR_LOWER + CHAR_BITS'(nib - NIB_TEN);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/utoa_if.sv =====
// ----------------------------------------------------------------------------
// utoa_if
// Valid/ready channels of the converter: number requests in, digits out.
// ----------------------------------------------------------------------------
interface utoa_in_if;
    logic                          valid;
    logic                          ready;
    logic [utoa_pkg::IN_BITS-1:0]  value;
    logic [utoa_pkg::OPC_BITS-1:0] opcode;

    modport source (output valid, output value, output opcode, input ready);
    modport sink (input valid, input value, input opcode, output ready);
endinterface

interface utoa_out_if;
    logic                           valid;
    logic                           ready;
    logic [utoa_pkg::CHAR_BITS-1:0] digit_char;
    logic                           last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink (input valid, input digit_char, input last, output ready);
endinterface

// ===== hw/rtl/unsigned_to_ascii_digits.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// Writes an unsigned number as ASCII decimal or hexadecimal digits.
//
// Requests arrive on i_req (value, opcode: 0 decimal, 1 lower-case hex,
// 2 or 3 upper-case hex). Digits leave on o_dig, most significant first,
// without leading zeros; zero gives a single '0'. The final digit of each
// number has last set. Both channels use valid/ready.
// A two-entry request queue sits in front of the conversion engine, so new
// requests are taken while the engine or the receiver is busy.
// A decimal request runs through the shift-and-add BCD converter, one input
// bit per cycle; the engine then drops the leading zero digits and sends the
// rest. Hex requests skip the converter. The engine takes a new request only
// after the final digit of the previous one has gone to the output register.
// Reset clears the queue, the engine and the output register. When the
// receiver stalls, the current digit holds and the engine waits to send the next.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits #(
    parameter int VALUE_BITS = utoa_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utoa_in_if.sink     i_req,
    utoa_out_if.source  o_dig
);

    logic                  job_valid;
    logic                  job_ready;
    logic [VALUE_BITS-1:0] job_value;
    utoa_pkg::t_mode       job_mode;

    utoa_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job_value (job_value),
        .o_job_mode  (job_mode)
    );

    utoa_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job_value (job_value),
        .i_job_mode  (job_mode),
        .o_dig       (o_dig)
    );

endmodule

// ===== hw/rtl/utoa_front.sv =====
// ----------------------------------------------------------------------------
// utoa_front
// Accepts requests, masks the value and decodes the mode, and holds up to
// two classified requests for the conversion engine.
// ----------------------------------------------------------------------------
module utoa_front #(
    parameter int VALUE_BITS = utoa_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    utoa_in_if.sink               i_req,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output logic [VALUE_BITS-1:0] o_job_value,
    output utoa_pkg::t_mode       o_job_mode
);

    logic [VALUE_BITS-1:0] r_q_value [2];
    utoa_pkg::t_mode       r_q_mode  [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_count;
    logic                  push;
    logic                  pop;
    utoa_pkg::t_mode       in_mode;

    assign i_req.ready = (r_count != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = o_job_valid && i_job_ready;

    always_comb begin
        priority if (i_req.opcode[1]) begin
            in_mode = utoa_pkg::MODE_UPPER;
        end else if (i_req.opcode[0]) begin
            in_mode = utoa_pkg::MODE_LOWER;
        end else begin
            in_mode = utoa_pkg::MODE_DEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_value[r_wr_ptr] <= i_req.value[VALUE_BITS-1:0];
            r_q_mode[r_wr_ptr]  <= in_mode;
        end
    end

    assign o_job_valid = (r_count != 2'd0);
    assign o_job_value = r_q_value[r_rd_ptr];
    assign o_job_mode  = r_q_mode[r_rd_ptr];

endmodule

// ===== hw/rtl/utoa_back.sv =====
// ----------------------------------------------------------------------------
// utoa_back
// Conversion engine: decimal requests go binary to BCD by shift-and-add-three,
// one bit per cycle; then digits leave most significant first, leading zeros dropped.
// ----------------------------------------------------------------------------
module utoa_back #(
    parameter int VALUE_BITS = utoa_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  logic [VALUE_BITS-1:0] i_job_value,
    input  utoa_pkg::t_mode       i_job_mode,
    utoa_out_if.source            o_dig
);

    localparam int DEC_DIGITS = utoa_pkg::dec_digits(VALUE_BITS);
    localparam int HEX_DIGITS = utoa_pkg::hex_digits(VALUE_BITS);
    localparam int NB         = utoa_pkg::NIB_BITS;
    localparam int DIG_W      = DEC_DIGITS * NB;
    localparam int HEX_W      = HEX_DIGITS * NB;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    utoa_pkg::t_state               r_state;
    utoa_pkg::t_state               n_state;
    logic [DIG_W-1:0]               r_digits;
    logic [DIG_W-1:0]               n_digits;
    logic [VALUE_BITS-1:0]          r_bin;
    logic [VALUE_BITS-1:0]          n_bin;
    logic [CNT_W-1:0]               r_cnt;
    logic [CNT_W-1:0]               n_cnt;
    logic                           r_started;
    logic                           n_started;
    logic                           r_upper;
    logic                           n_upper;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic [utoa_pkg::CHAR_BITS-1:0] r_out_char;
    logic [utoa_pkg::CHAR_BITS-1:0] n_out_char;
    logic                           r_out_last;
    logic                           n_out_last;
    logic [DIG_W-1:0]               dabbled;
    logic [NB-1:0]                  top_nib;
    logic                           is_last;
    logic                           out_free;

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_digits[i*NB +: NB] >= utoa_pkg::NIB_FIVE) begin
                dabbled[i*NB +: NB] = r_digits[i*NB +: NB] + utoa_pkg::NIB_THREE;
            end else begin
                dabbled[i*NB +: NB] = r_digits[i*NB +: NB];
            end
        end
    end

    assign top_nib  = r_digits[DIG_W-1 -: NB];
    assign is_last  = (r_cnt == CNT_W'(1));
    assign out_free = !r_out_valid || o_dig.ready;

    always_comb begin
        n_state     = r_state;
        n_digits    = r_digits;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_started   = r_started;
        n_upper     = r_upper;
        n_out_valid = r_out_valid && !o_dig.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_job_ready = 1'b0;
        unique case (r_state)
            utoa_pkg::ST_IDLE: begin
                o_job_ready = 1'b1;
                n_started   = 1'b0;
                n_upper     = (i_job_mode == utoa_pkg::MODE_UPPER);
                if (i_job_valid) begin
                    if (i_job_mode == utoa_pkg::MODE_DEC) begin
                        n_bin    = i_job_value;
                        n_digits = '0;
                        n_cnt    = CNT_W'(VALUE_BITS);
                        n_state  = utoa_pkg::ST_CONV;
                    end else begin
                        n_digits = DIG_W'(i_job_value) << (DIG_W - HEX_W);
                        n_cnt    = CNT_W'(HEX_DIGITS);
                        n_state  = utoa_pkg::ST_EMIT;
                    end
                end
            end
            utoa_pkg::ST_CONV: begin
                n_digits = {dabbled[DIG_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin    = r_bin << 1;
                n_cnt    = r_cnt - CNT_W'(1);
                if (is_last) begin
                    n_cnt   = CNT_W'(DEC_DIGITS);
                    n_state = utoa_pkg::ST_EMIT;
                end
            end
            utoa_pkg::ST_EMIT: begin
                if (top_nib == '0 && !r_started && !is_last) begin
                    n_digits = r_digits << NB;
                    n_cnt    = r_cnt - CNT_W'(1);
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = utoa_pkg::nib_to_char(top_nib, r_upper);
                    n_out_last  = is_last;
                    n_digits    = r_digits << NB;
                    n_cnt       = r_cnt - CNT_W'(1);
                    n_started   = 1'b1;
                    if (is_last) begin
                        n_state = utoa_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = utoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= utoa_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits   <= n_digits;
        r_bin      <= n_bin;
        r_upper    <= n_upper;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_dig.valid      = r_out_valid;
    assign o_dig.digit_char = r_out_char;
    assign o_dig.last       = r_out_last;

`ifndef ASSERT_OFF
    a_conv_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == utoa_pkg::ST_CONV |-> r_cnt != '0)
        else $error("Conversion running with an empty bit count.");

    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == utoa_pkg::ST_EMIT |-> r_cnt != '0)
        else $error("Digit output running with no digits left.");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == utoa_pkg::ST_EMIT && is_last && out_free |=> r_state == utoa_pkg::ST_IDLE)
        else $error("Engine did not return to idle after the final digit.");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_char >= utoa_pkg::CHAR_ZERO && r_out_char <= 7'h66)
        else $error("Digit character outside the ASCII digit range.");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of unsigned_to_ascii_digits. Number requests are
// sent in bursts with random gaps while the digit receiver stalls on a
// changing pattern. Each accepted request is turned into its expected digit
// string by a local decimal and hexadecimal formatter, and every digit that
// leaves the block is compared in order against that string.
// ----------------------------------------------------------------------------
module tb;

    localparam int VALUE_BITS     = 64;
    localparam int MAX_DIGITS     = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct packed {
        logic [utoa_pkg::CHAR_BITS-1:0] digit_char;
        logic                           last;
    } t_digit;

    logic i_clk;
    logic i_rst_n;

    utoa_in_if  req_if ();
    utoa_out_if dig_if ();

    unsigned_to_ascii_digits #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_dig   (dig_if.source)
    );

    t_digit expected_digits[$];
    int     mismatch_count = 0;
    int     idle_cycles    = 0;
    int     burst_left     = 0;
    int     stall_style    = 0;
    int     stall_cycle    = 0;
    int     stall_hold     = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [utoa_pkg::IN_BITS-1:0] value_mask();
        if (VALUE_BITS >= utoa_pkg::IN_BITS) begin
            return '1;
        end
        return (64'd1 << VALUE_BITS) - 64'd1;
    endfunction

    function automatic void predict_digits(
        input logic [utoa_pkg::IN_BITS-1:0]  value,
        input logic [utoa_pkg::OPC_BITS-1:0] opcode
    );
        logic [utoa_pkg::IN_BITS-1:0]   v;
        logic [utoa_pkg::CHAR_BITS-1:0] digit_buf [MAX_DIGITS];
        logic [utoa_pkg::NIB_BITS-1:0]  nib;
        utoa_pkg::t_mode                mode;
        t_digit                         d;
        int                             n;
        v = value & value_mask();
        n = 0;
        if (opcode[1]) begin
            mode = utoa_pkg::MODE_UPPER;
        end else if (opcode[0]) begin
            mode = utoa_pkg::MODE_LOWER;
        end else begin
            mode = utoa_pkg::MODE_DEC;
        end
        if (mode == utoa_pkg::MODE_DEC) begin
            do begin
                digit_buf[n] = utoa_pkg::CHAR_ZERO
                             + utoa_pkg::CHAR_BITS'(v % 64'd10);
                v = v / 64'd10;
                n++;
            end while (v != 0 && n < MAX_DIGITS);
        end else begin
            do begin
                nib = v[utoa_pkg::NIB_BITS-1:0];
                if (nib < utoa_pkg::NIB_TEN) begin
                    digit_buf[n] = utoa_pkg::CHAR_ZERO + utoa_pkg::CHAR_BITS'(nib);
                end else if (mode == utoa_pkg::MODE_UPPER) begin
                    digit_buf[n] = utoa_pkg::CHAR_UPPER
                                 + utoa_pkg::CHAR_BITS'(nib - utoa_pkg::NIB_TEN);
                end else begin
                    digit_buf[n] = utoa_pkg::CHAR_LOWER
                                 + utoa_pkg::CHAR_BITS'(nib - utoa_pkg::NIB_TEN);
                end
                v = v >> utoa_pkg::NIB_BITS;
                n++;
            end while (v != 0 && n < MAX_DIGITS);
        end
        for (int k = 0; k < n; k++) begin
            d.digit_char = digit_buf[n-1-k];
            d.last       = (k == n - 1);
            expected_digits.push_back(d);
        end
    endfunction

    // Random number of random bit length, so short and long strings both occur.
    function automatic logic [utoa_pkg::IN_BITS-1:0] random_value();
        logic [utoa_pkg::IN_BITS-1:0] r;
        int                           len;
        len = $urandom_range(0, utoa_pkg::IN_BITS);
        r   = {$urandom, $urandom};
        if (len == 0) begin
            return '0;
        end
        if (len < utoa_pkg::IN_BITS) begin
            r = r & ((64'd1 << len) - 64'd1);
        end
        r[len-1] = 1'b1;
        return r;
    endfunction

    task automatic send_request(input logic [utoa_pkg::IN_BITS-1:0]  value,
                                input logic [utoa_pkg::OPC_BITS-1:0] opcode);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        req_if.valid  <= 1'b1;
        req_if.value  <= value;
        req_if.opcode <= opcode;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        predict_digits(value, opcode);
    endtask

    task automatic test_zero_value();
        for (int op = 0; op < 4; op++) begin
            send_request('0, utoa_pkg::OPC_BITS'(op));
        end
    endtask

    task automatic test_extremes();
        for (int op = 0; op < 4; op++) begin
            send_request('1, utoa_pkg::OPC_BITS'(op));
        end
        send_request(64'd10000000000000000000, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_DEC));
        send_request(64'd9999999999999999999, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_DEC));
        send_request(64'd1, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_DEC));
        send_request(64'd9, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_DEC));
        send_request(64'd10, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_DEC));
        send_request(64'h8000_0000_0000_0000, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_LOWER));
        send_request(64'hF, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_LOWER));
        send_request(64'h10, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_UPPER));
    endtask

    // Opcode three must behave as upper-case hex.
    task automatic test_hex_letters();
        send_request(64'hfedc_ba98_7654_3210, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_LOWER));
        send_request(64'hfedc_ba98_7654_3210, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_UPPER));
        send_request(64'hfedc_ba98_7654_3210, 2'b11);
        send_request(64'h0123_4567_89ab_cdef, utoa_pkg::OPC_BITS'(utoa_pkg::MODE_LOWER));
    endtask

    task automatic test_random_decimal();
        repeat (200) begin
            send_request(random_value(), utoa_pkg::OPC_BITS'(utoa_pkg::MODE_DEC));
        end
    endtask

    task automatic test_random_hex();
        repeat (150) begin
            send_request(random_value(), ($urandom_range(0, 1) == 0) ?
                         utoa_pkg::OPC_BITS'(utoa_pkg::MODE_LOWER) :
                         utoa_pkg::OPC_BITS'($urandom_range(2, 3)));
        end
    endtask

    task automatic test_random_mixed();
        repeat (150) begin
            send_request(random_value(), utoa_pkg::OPC_BITS'($urandom_range(0, 3)));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.value  = '0;
        req_if.opcode = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_zero_value();
        test_extremes();
        test_hex_letters();
        test_random_decimal();
        test_random_hex();
        test_random_mixed();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_digits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // The receiver switches between four stall styles, picked at random.
    always @(negedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 256 == 0) begin
            stall_style = $urandom_range(0, 3);
        end
        case (stall_style)
            0: begin
                dig_if.ready <= 1'b1;
            end
            1: begin
                dig_if.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                dig_if.ready <= (stall_cycle % 7) >= 3;
            end
            default: begin
                if (stall_hold > 0) begin
                    stall_hold--;
                    dig_if.ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_hold = $urandom_range(1, 20);
                    dig_if.ready <= 1'b0;
                end else begin
                    dig_if.ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_digit exp_d;
        if (i_rst_n && dig_if.valid && dig_if.ready) begin
            if (expected_digits.size() == 0) begin
                $display("%0t: expected no digit, actual %h last %b", $time,
                         dig_if.digit_char, dig_if.last);
                mismatch_count++;
            end else begin
                exp_d = expected_digits.pop_front();
                if (dig_if.digit_char !== exp_d.digit_char) begin
                    $display("%0t: digit_char expected %h actual %h", $time,
                             exp_d.digit_char, dig_if.digit_char);
                    mismatch_count++;
                end
                if (dig_if.last !== exp_d.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             exp_d.last, dig_if.last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (dig_if.valid && dig_if.ready)) begin
                idle_cycles = 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end else begin
                idle_cycles++;
            end
        end
    end

endmodule
